FILE: rtl/source_tokenizer_macros.svh
// source_tokenizer_macros.svh: assertion macros for the tokenizer rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// clocked assertion, off while reset is asserted
`define STOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define STOK_NEVER(lbl, cond, msg) \
  `STOK_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/stok_pkg.sv
// stok_pkg: types, token kinds, character codes and keyword tables of the tokenizer
// no dependencies
`default_nettype none

package stok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_STRING,
    MODE_OPER,
    MODE_SKIP
  } scan_mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  localparam logic [4:0] KIND_NUMBER       = 5'd0;
  localparam logic [4:0] KIND_STRING       = 5'd1;
  localparam logic [4:0] KIND_IDENT        = 5'd2;
  localparam logic [4:0] KIND_KEYWORD0     = 5'd3;
  localparam logic [4:0] KIND_LPAREN       = 5'd9;
  localparam logic [4:0] KIND_RPAREN       = 5'd10;
  localparam logic [4:0] KIND_ADD          = 5'd11;
  localparam logic [4:0] KIND_SUB          = 5'd12;
  localparam logic [4:0] KIND_DIV          = 5'd13;
  localparam logic [4:0] KIND_MUL          = 5'd14;
  localparam logic [4:0] KIND_OPER0        = 5'd15;
  localparam logic [4:0] KIND_UNEXPECTED   = 5'd23;
  localparam logic [4:0] KIND_UNTERMINATED = 5'd24;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;

  localparam int unsigned NUM_KW = 6;
  localparam logic [5:0] KW_ALL  = 6'h3F;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [39:0] KW_TEXT [NUM_KW] = '{
    40'("def"), 40'("var"), 40'("true"), 40'("false"), 40'("if"), 40'("else")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4};

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // character j of keyword k, j below the keyword length
  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] j);
    logic [39:0] txt;
    int          sh;
    txt = KW_TEXT[k];
    sh  = 8 * (int'(KW_LEN[k]) - 1 - int'(j));
    if (sh < 0) begin
      return 8'h00;
    end
    return txt[sh +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/source_tokenizer.sv
// source_tokenizer: streaming lexer top level, byte in, tokens out
// depends on stok_pkg, stok_step and source_tokenizer_macros.svh
`default_nettype none

// Streaming lexer. Source bytes arrive one word at a time with an end-of-source
// flag on the final byte; tokens leave as (kind, start offset, length), and the
// host slices the literal text from its own copy of the source. Recognized are
// decimal numbers, identifiers, the keywords def var true false if else,
// double-quoted strings without escapes (empty allowed, offsets exclude the
// quotes), single-character operators and the comparisons <= >= != ==.
// Whitespace is skipped. An unexpected byte gives an error token, then the
// rest of the source is dropped silently; a string left open at end of source
// gives an unterminated-string token. last_of_run_o marks the final token a
// given byte produced. After the end-of-source byte the scanner restarts at
// offset 0. Offsets and lengths saturate at 2^POSITION_BITS-1 and then at 65535
// on the ports.
// Throughput is one byte per cycle while out_ready_i holds high. A byte that
// closes one token and opens or closes another yields two tokens; the
// two-entry result buffer drains one token per cycle, so such a byte holds up
// the next byte while the buffer drains. A byte passes an input register, then
// the scanner logic writes its tokens to the result buffer. No stall after reset.

module source_tokenizer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);
  import stok_pkg::*;

  localparam int unsigned PB = POSITION_BITS;

  // input register
  logic       in_vld_q;
  logic [7:0] data_q;
  logic       eos_q;

  // scanner state
  scan_mode_e    mode_q, mode_d;
  logic [1:0]    pend_q, pend_d;
  logic [PB-1:0] start_q, start_d;
  logic [PB-1:0] runlen_q, runlen_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [5:0]    kwc_q, kwc_d;

  // two-entry result buffer, res0_q is the head shown on the ports
  tok_t       res0_q, res1_q;
  logic [1:0] ocnt_q;

  logic [1:0] step_cnt;
  tok_t       step_r0, step_r1;
  logic       room;
  logic       adv;
  logic       pop;

  // the buffer must be empty once the head goes out this cycle
  assign room = (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && out_ready_i);
  assign adv  = in_vld_q && room;
  assign pop  = out_valid_o && out_ready_i;

  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      eos_q  <= end_of_source_i;
    end
  end

  stok_step #(
    .PB (PB)
  ) u_step (
    .mode_i    (mode_q),
    .pend_i    (pend_q),
    .start_i   (start_q),
    .runlen_i  (runlen_q),
    .pos_i     (pos_q),
    .kwc_i     (kwc_q),
    .data_i    (data_q),
    .eos_i     (eos_q),
    .mode_o    (mode_d),
    .pend_o    (pend_d),
    .start_o   (start_d),
    .runlen_o  (runlen_d),
    .pos_o     (pos_d),
    .kwc_o     (kwc_d),
    .res_cnt_o (step_cnt),
    .res0_o    (step_r0),
    .res1_o    (step_r1)
  );

  // scanner state moves only when a byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= '0;
      start_q  <= '0;
      runlen_q <= '0;
      pos_q    <= '0;
      kwc_q    <= KW_ALL;
    end else if (adv) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      start_q  <= start_d;
      runlen_q <= runlen_d;
      pos_q    <= pos_d;
      kwc_q    <= kwc_d;
    end
  end

  // result buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else if (adv) begin
      ocnt_q <= step_cnt;
    end else if (pop) begin
      ocnt_q <= ocnt_q - 2'd1;
    end
  end

  // result buffer payload: a new pair always lands in an empty buffer
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res0_q <= step_r0;
      res1_q <= step_r1;
    end else if (pop && (ocnt_q == 2'd2)) begin
      res0_q <= res1_q;
    end
  end

  assign out_valid_o    = (ocnt_q != 2'd0);
  assign token_kind_o   = res0_q.kind;
  assign token_start_o  = res0_q.start;
  assign token_length_o = res0_q.length;
  assign last_of_run_o  = res0_q.last;

  `include "source_tokenizer_macros.svh"

  // a byte is only consumed when its tokens fit
  `STOK_NEVER(a_no_overrun, adv && (ocnt_q == 2'd2), "byte consumed into a full result buffer")
  // two buffered tokens come from one byte, so the head is never the last
  `STOK_ASSERT(a_pair_order, (ocnt_q == 2'd2) |-> !res0_q.last, "head of a pair marked last")
  // end of source restarts the offset count
  `STOK_ASSERT(a_eos_restart, (adv && eos_q) |=> (pos_q == '0), "offset not cleared after end")
  // the final buffered token always closes its byte's run
  `STOK_ASSERT(a_tail_last, (ocnt_q == 2'd1) |-> res0_q.last, "single token not marked last")

endmodule

`default_nettype wire

FILE: rtl/stok_step.sv
// stok_step: next scanner state and up to two tokens for one source byte
// depends on stok_pkg
`default_nettype none

module stok_step #(
  parameter int unsigned PB = 16
) (
  input  stok_pkg::scan_mode_e mode_i,
  input  logic [1:0]           pend_i,
  input  logic [PB-1:0]        start_i,
  input  logic [PB-1:0]        runlen_i,
  input  logic [PB-1:0]        pos_i,
  input  logic [5:0]           kwc_i,
  input  logic [7:0]           data_i,
  input  logic                 eos_i,
  output stok_pkg::scan_mode_e mode_o,
  output logic [1:0]           pend_o,
  output logic [PB-1:0]        start_o,
  output logic [PB-1:0]        runlen_o,
  output logic [PB-1:0]        pos_o,
  output logic [5:0]           kwc_o,
  output logic [1:0]           res_cnt_o,
  output stok_pkg::tok_t       res0_o,
  output stok_pkg::tok_t       res1_o
);
  import stok_pkg::*;

  localparam int unsigned EW = (PB > 16) ? PB : 16;

  function automatic logic [PB-1:0] sat_inc(logic [PB-1:0] v);
    return (v == {PB{1'b1}}) ? v : v + PB'(1);
  endfunction

  function automatic logic [15:0] sat16(logic [PB-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    return (ve > EW'(16'hFFFF)) ? 16'hFFFF : ve[15:0];
  endfunction

  function automatic tok_t mk(logic [4:0] kind, logic [PB-1:0] st, logic [PB-1:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = sat16(st);
    t.length = sat16(len);
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [5:0] kw_filter(logic [5:0] mask, logic [PB-1:0] idx,
                                           logic [7:0] c);
    logic [5:0] keep;
    keep = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      keep[i] = mask[i] && (idx < PB'(KW_LEN[i])) && (kw_char(3'(i), idx[2:0]) == c);
    end
    return keep;
  endfunction

  // first surviving keyword whose length matches wins
  function automatic logic [4:0] ident_kind(logic [5:0] mask, logic [PB-1:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (mask[i] && (len == PB'(KW_LEN[i]))) begin
        kind = KIND_KEYWORD0 + 5'(i);
      end
    end
    return kind;
  endfunction

  function automatic logic [4:0] oper_kind(logic [1:0] pend, logic with_eq);
    return KIND_OPER0 + {2'b00, pend, with_eq};
  endfunction

  scan_mode_e    mode;
  logic [1:0]    pend;
  logic [PB-1:0] st, rl, pos_n;
  logic [5:0]    kw;
  logic          fresh;
  logic          va, vb, ve;
  tok_t          ea, eb, ee;
  logic [1:0]    cnt;
  tok_t          r0, r1;

  always_comb begin
    mode  = mode_i;
    pend  = pend_i;
    st    = start_i;
    rl    = runlen_i;
    kw    = kwc_i;
    pos_n = pos_i;
    fresh = 1'b0;
    va    = 1'b0;
    vb    = 1'b0;
    ve    = 1'b0;
    ea    = '0;
    eb    = '0;
    ee    = '0;

    // continue the open token
    unique case (mode_i)
      MODE_SKIP: begin
      end
      MODE_STRING: begin
        if (data_i == CH_QUOTE) begin
          va   = 1'b1;
          ea   = mk(KIND_STRING, start_i, runlen_i);
          mode = MODE_IDLE;
        end else begin
          rl = sat_inc(runlen_i);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(data_i)) begin
          rl = sat_inc(runlen_i);
        end else begin
          va    = 1'b1;
          ea    = mk(KIND_NUMBER, start_i, runlen_i);
          fresh = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_letter(data_i) || is_digit(data_i) || (data_i == CH_UNDERSCORE)) begin
          kw = kw_filter(kwc_i, runlen_i, data_i);
          rl = sat_inc(runlen_i);
        end else begin
          va    = 1'b1;
          ea    = mk(ident_kind(kwc_i, runlen_i), start_i, runlen_i);
          fresh = 1'b1;
        end
      end
      MODE_OPER: begin
        if (data_i == CH_EQUAL) begin
          va   = 1'b1;
          ea   = mk(oper_kind(pend_i, 1'b1), start_i, PB'(2));
          mode = MODE_IDLE;
        end else begin
          va    = 1'b1;
          ea    = mk(oper_kind(pend_i, 1'b0), start_i, PB'(1));
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // byte starts a new token
    if (fresh) begin
      mode = MODE_IDLE;
      if (is_digit(data_i)) begin
        mode = MODE_NUMBER;
        st   = pos_i;
        rl   = PB'(1);
      end else if (is_letter(data_i)) begin
        mode = MODE_IDENT;
        st   = pos_i;
        kw   = kw_filter(KW_ALL, '0, data_i);
        rl   = PB'(1);
      end else begin
        case (data_i) inside
          CH_LESS: begin
            mode = MODE_OPER;
            pend = 2'd0;
            st   = pos_i;
          end
          CH_GREATER: begin
            mode = MODE_OPER;
            pend = 2'd1;
            st   = pos_i;
          end
          CH_BANG: begin
            mode = MODE_OPER;
            pend = 2'd2;
            st   = pos_i;
          end
          CH_EQUAL: begin
            mode = MODE_OPER;
            pend = 2'd3;
            st   = pos_i;
          end
          CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
          end
          CH_QUOTE: begin
            mode = MODE_STRING;
            st   = sat_inc(pos_i);
            rl   = '0;
          end
          CH_LPAREN: begin
            vb = 1'b1;
            eb = mk(KIND_LPAREN, pos_i, PB'(1));
          end
          CH_RPAREN: begin
            vb = 1'b1;
            eb = mk(KIND_RPAREN, pos_i, PB'(1));
          end
          CH_PLUS: begin
            vb = 1'b1;
            eb = mk(KIND_ADD, pos_i, PB'(1));
          end
          CH_MINUS: begin
            vb = 1'b1;
            eb = mk(KIND_SUB, pos_i, PB'(1));
          end
          CH_SLASH: begin
            vb = 1'b1;
            eb = mk(KIND_DIV, pos_i, PB'(1));
          end
          CH_STAR: begin
            vb = 1'b1;
            eb = mk(KIND_MUL, pos_i, PB'(1));
          end
          default: begin
            vb   = 1'b1;
            eb   = mk(KIND_UNEXPECTED, pos_i, PB'(1));
            mode = MODE_SKIP;
          end
        endcase
      end
    end

    // end of source flushes the open token and restarts the scanner
    if (eos_i) begin
      unique case (mode)
        MODE_NUMBER: begin
          ve = 1'b1;
          ee = mk(KIND_NUMBER, st, rl);
        end
        MODE_IDENT: begin
          ve = 1'b1;
          ee = mk(ident_kind(kw, rl), st, rl);
        end
        MODE_STRING: begin
          ve = 1'b1;
          ee = mk(KIND_UNTERMINATED, st, rl);
        end
        MODE_OPER: begin
          ve = 1'b1;
          ee = mk(oper_kind(pend, 1'b0), st, PB'(1));
        end
        default: begin
        end
      endcase
      mode  = MODE_IDLE;
      pend  = '0;
      st    = '0;
      rl    = '0;
      kw    = KW_ALL;
      pos_n = '0;
    end else begin
      pos_n = sat_inc(pos_i);
    end
  end

  // pack the emitted tokens in order, at most two
  always_comb begin
    r0 = va ? ea : (vb ? eb : ee);
    r1 = (va && vb) ? eb : ee;
    if ((va && vb) || (va && ve) || (vb && ve)) begin
      cnt = 2'd2;
    end else if (va || vb || ve) begin
      cnt = 2'd1;
    end else begin
      cnt = 2'd0;
    end
    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  assign mode_o    = mode;
  assign pend_o    = pend;
  assign start_o   = st;
  assign runlen_o  = rl;
  assign pos_o     = pos_n;
  assign kwc_o     = kw;
  assign res_cnt_o = cnt;
  assign res0_o    = r0;
  assign res1_o    = r1;

endmodule

`default_nettype wire

FILE: test/source_tokenizer_checker.sv
`timescale 1ns / 1ps
// source_tokenizer_checker: watches the byte and token channels of source_tokenizer,
// predicts every token from the accepted bytes and compares; depends on stok_pkg

module source_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_source_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  token_kind_i,
  input  logic [15:0] token_start_i,
  input  logic [15:0] token_length_i,
  input  logic        last_of_run_i,
  output int unsigned outstanding_o,
  output int unsigned errors_o
);
  import stok_pkg::*;

  typedef enum logic [1:0] {
    OPC_LESS,
    OPC_GREATER,
    OPC_BANG,
    OPC_EQUAL
  } cmp_op_e;

  // lexer state as the block should hold it
  scan_mode_e  mode;
  cmp_op_e     held_op;
  logic [15:0] tok_org;
  logic [15:0] tok_len;
  logic [15:0] byte_pos;
  logic [5:0]  kw_live;

  tok_t        tokens_due [$];
  int unsigned err_count;

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic num_char(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic alpha_char(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic string keyword_word(int k);
    case (k)
      0:       return "def";
      1:       return "var";
      2:       return "true";
      3:       return "false";
      4:       return "if";
      default: return "else";
    endcase
  endfunction

  // keep the keywords whose character at index idx is c
  function automatic logic [5:0] narrow_keywords(logic [5:0] live, logic [15:0] idx,
                                                 logic [7:0] c);
    logic [5:0] keep;
    string      w;
    keep = '0;
    for (int k = 0; k < 6; k++) begin
      w = keyword_word(k);
      if (live[k] && (int'(idx) < w.len())) begin
        if (8'(w[int'(idx)]) == c) keep[k] = 1'b1;
      end
    end
    return keep;
  endfunction

  // a surviving candidate of full length makes the identifier a keyword
  function automatic logic [4:0] ident_kind(logic [5:0] live, logic [15:0] len);
    string w;
    for (int k = 0; k < 6; k++) begin
      w = keyword_word(k);
      if (live[k] && (int'(len) == w.len())) return KIND_KEYWORD0 + 5'(k);
    end
    return KIND_IDENT;
  endfunction

  function automatic tok_t tok_of(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  task automatic clear_scan();
    mode     = MODE_IDLE;
    held_op  = OPC_LESS;
    tok_org  = '0;
    tok_len  = '0;
    byte_pos = '0;
    kw_live  = KW_ALL;
  endtask

  // tokens caused by one source byte, queued in order
  task automatic lex_byte(input logic [7:0] c, input logic eos);
    tok_t        made [$];
    logic [15:0] here;
    logic        rescan;
    here   = byte_pos;
    rescan = 1'b0;
    case (mode)
      MODE_SKIP: begin
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          made = {made, tok_of(KIND_STRING, tok_org, tok_len)};
          mode = MODE_IDLE;
        end else begin
          tok_len = sat_up(tok_len);
        end
      end
      MODE_NUMBER: begin
        if (num_char(c)) begin
          tok_len = sat_up(tok_len);
        end else begin
          made   = {made, tok_of(KIND_NUMBER, tok_org, tok_len)};
          rescan = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (alpha_char(c) || num_char(c) || (c == CH_UNDERSCORE)) begin
          kw_live = narrow_keywords(kw_live, tok_len, c);
          tok_len = sat_up(tok_len);
        end else begin
          made   = {made, tok_of(ident_kind(kw_live, tok_len), tok_org, tok_len)};
          rescan = 1'b1;
        end
      end
      MODE_OPER: begin
        if (c == CH_EQUAL) begin
          made = {made, tok_of(KIND_OPER0 + 5'({held_op, 1'b1}), tok_org, 16'd2)};
          mode = MODE_IDLE;
        end else begin
          made   = {made, tok_of(KIND_OPER0 + 5'({held_op, 1'b0}), tok_org, 16'd1)};
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    // a byte that ended a number, identifier or lone operator, or any byte seen while idle, starts afresh
    if (rescan) begin
      mode = MODE_IDLE;
      if (num_char(c)) begin
        mode    = MODE_NUMBER;
        tok_org = here;
        tok_len = 16'd1;
      end else if (alpha_char(c)) begin
        mode    = MODE_IDENT;
        tok_org = here;
        kw_live = narrow_keywords(KW_ALL, 16'd0, c);
        tok_len = 16'd1;
      end else begin
        case (c)
          CH_LESS:    begin mode = MODE_OPER; held_op = OPC_LESS;    tok_org = here; end
          CH_GREATER: begin mode = MODE_OPER; held_op = OPC_GREATER; tok_org = here; end
          CH_BANG:    begin mode = MODE_OPER; held_op = OPC_BANG;    tok_org = here; end
          CH_EQUAL:   begin mode = MODE_OPER; held_op = OPC_EQUAL;   tok_org = here; end
          CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
          end
          CH_QUOTE: begin
            // content starts after the opening quote
            mode    = MODE_STRING;
            tok_org = sat_up(here);
            tok_len = '0;
          end
          CH_LPAREN: made = {made, tok_of(KIND_LPAREN, here, 16'd1)};
          CH_RPAREN: made = {made, tok_of(KIND_RPAREN, here, 16'd1)};
          CH_PLUS:   made = {made, tok_of(KIND_ADD, here, 16'd1)};
          CH_MINUS:  made = {made, tok_of(KIND_SUB, here, 16'd1)};
          CH_SLASH:  made = {made, tok_of(KIND_DIV, here, 16'd1)};
          CH_STAR:   made = {made, tok_of(KIND_MUL, here, 16'd1)};
          default: begin
            made = {made, tok_of(KIND_UNEXPECTED, here, 16'd1)};
            mode = MODE_SKIP;
          end
        endcase
      end
    end

    // end of source flushes an open token and restarts at offset 0
    if (eos) begin
      case (mode)
        MODE_NUMBER: made = {made, tok_of(KIND_NUMBER, tok_org, tok_len)};
        MODE_IDENT:  made = {made, tok_of(ident_kind(kw_live, tok_len), tok_org, tok_len)};
        MODE_STRING: made = {made, tok_of(KIND_UNTERMINATED, tok_org, tok_len)};
        MODE_OPER:   made = {made, tok_of(KIND_OPER0 + 5'({held_op, 1'b0}), tok_org, 16'd1)};
        default: begin
        end
      endcase
      clear_scan();
    end else begin
      byte_pos = sat_up(here);
    end

    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    tokens_due = {tokens_due, made};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tok_t due;
    logic miss;
    if (!rst_ni) begin
      clear_scan();
      tokens_due.delete();
      err_count = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_byte(data_byte_i, end_of_source_i);
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          err_count++;
          $display("%0t: expected no token, got kind %0d start %0d length %0d last %0b",
                   $time, token_kind_i, token_start_i, token_length_i, last_of_run_i);
        end else begin
          due  = tokens_due.pop_front();
          miss = (token_kind_i !== due.kind) || (token_start_i !== due.start) ||
                 (token_length_i !== due.length) || (last_of_run_i !== due.last);
          if (miss) begin
            err_count++;
            $display("%0t: expected kind %0d start %0d length %0d last %0b, got %0d %0d %0d %0b",
                     $time, due.kind, due.start, due.length, due.last,
                     token_kind_i, token_start_i, token_length_i, last_of_run_i);
          end
        end
      end
      outstanding_o <= tokens_due.size();
      errors_o      <= err_count;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus and verdict for source_tokenizer
// depends on stok_pkg, source_tokenizer and source_tokenizer_checker

module testbench;
  import stok_pkg::*;

  localparam int unsigned RANDOM_WORDS = 650;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  data_byte     = 8'h00;
  logic        end_of_source = 1'b0;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;
  int unsigned outstanding;
  int unsigned errors;

  // source under construction and sender pacing
  logic [7:0]  src_bytes [$];
  logic        src_dropped  = 1'b0;
  int unsigned random_items = 0;
  logic        tx_quiet     = 1'b0;

  always #10 clk_i = ~clk_i;

  source_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_source_i (end_of_source),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .token_kind_o    (token_kind),
    .token_start_o   (token_start),
    .token_length_o  (token_length),
    .last_of_run_o   (last_of_run)
  );

  source_tokenizer_checker token_watch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_source_i (end_of_source),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .token_kind_i    (token_kind),
    .token_start_i   (token_start),
    .token_length_i  (token_length),
    .last_of_run_i   (last_of_run),
    .outstanding_o   (outstanding),
    .errors_o        (errors)
  );

  // offer one word after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_source <= eos;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_text(input string s, input logic eos);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), eos && (i == s.len() - 1));
  endtask

  // stop offering, then wait for the checker to see every token out
  task automatic wait_all_tokens();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // bytes after a noise byte may be skipped by the block, so they are not counted
  task automatic put_byte(input logic [7:0] b);
    src_bytes = {src_bytes, b};
    if (!src_dropped) random_items++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(8'(s[i]));
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_tail();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return rand_letter();
    if (pick < 9) return rand_digit();
    return CH_UNDERSCORE;
  endfunction

  // a mostly well-formed source of 1..6 tokens, sometimes glued together,
  // now and then a noise byte or a string left open at the end
  task automatic build_source();
    int unsigned n_tok;
    int unsigned pick;
    int unsigned n;
    string       w;
    logic [7:0]  c;
    src_bytes.delete();
    src_dropped = 1'b0;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        put_byte(8'($urandom_range(0, 255)));
        src_dropped = 1'b1;
      end else if (pick < 22) begin
        n = $urandom_range(1, 4);
        repeat (n) put_byte(rand_digit());
      end else if (pick < 38) begin
        put_byte(rand_letter());
        n = $urandom_range(0, 5);
        repeat (n) put_byte(rand_tail());
      end else if (pick < 50) begin
        case ($urandom_range(0, 5))
          0:       w = "def";
          1:       w = "var";
          2:       w = "true";
          3:       w = "false";
          4:       w = "if";
          default: w = "else";
        endcase
        // exact keyword, keyword with a tail, or a keyword prefix
        case ($urandom_range(0, 3))
          0: begin
            put_text(w);
            put_byte(rand_tail());
          end
          1:       put_text(w.substr(0, w.len() - 2));
          default: put_text(w);
        endcase
      end else if (pick < 62) begin
        put_byte(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
          do begin
            c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(32, 126));
          end while (c == CH_QUOTE);
          put_byte(c);
        end
        if ((t != n_tok - 1) || ($urandom_range(0, 3) != 0)) put_byte(CH_QUOTE);
      end else if (pick < 76) begin
        case ($urandom_range(0, 5))
          0:       put_byte(CH_LPAREN);
          1:       put_byte(CH_RPAREN);
          2:       put_byte(CH_PLUS);
          3:       put_byte(CH_MINUS);
          4:       put_byte(CH_SLASH);
          default: put_byte(CH_STAR);
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       put_byte(CH_LESS);
          1:       put_byte(CH_GREATER);
          2:       put_byte(CH_BANG);
          default: put_byte(CH_EQUAL);
        endcase
        if ($urandom_range(0, 1)) put_byte(CH_EQUAL);
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 3))
          0:       put_byte(CH_SPACE);
          1:       put_byte(CH_TAB);
          2:       put_byte(CH_CR);
          default: put_byte(CH_LF);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    logic mid_pause_done;
    mid_pause_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: keyword then comparison, number flushed at end of source
    send_text("if>=9", 1'b1);
    // empty string, lone operator flushed at end of source
    send_text("\"\"=", 1'b1);
    // underscore cannot start a token, the rest is dropped
    send_text("_ab", 1'b1);
    send_byte(8'hFF, 1'b1);
    // identifier closed by an operator that is itself flushed
    send_text("a!", 1'b1);
    tx_quiet = 1'b1;
    // string still open at end of source
    send_text("\"q", 1'b1);
    // control byte, then a digit that must be ignored
    send_byte(8'h00, 1'b0);
    send_text("1", 1'b1);
    // keyword and paren out of one byte
    send_text("else)", 1'b1);

    // random sources; the receiver's long hold-off falls in here
    while (random_items < RANDOM_WORDS) begin
      build_source();
      tx_quiet = ($urandom_range(0, 3) == 0);
      foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
      if (!mid_pause_done && (random_items >= RANDOM_WORDS / 2)) begin
        wait_all_tokens();
        mid_pause_done = 1'b1;
      end
    end

    wait_all_tokens();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // token receiver: random stalls, bursts without any, one long hold-off
  initial begin : drain
    int unsigned wait_n;
    int unsigned taken;
    logic        rx_quiet;
    taken    = 0;
    rx_quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 16 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      wait_n = rx_quiet ? 0 : $urandom_range(0, 19);
      // long enough for the result buffer to fill and the input to stall
      if (taken == 120) wait_n = 300;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/stok_pkg.sv
rtl/stok_step.sv
rtl/source_tokenizer.sv
test/source_tokenizer_checker.sv
test/testbench.sv
